[hw/rtl/swm_pkg.sv]
package swm_pkg;

  localparam int MaxSteps = 24;
  localparam int CordicW = 30;
  localparam int ProdW = CordicW - 1 + 30;
  localparam logic [29:0] GainQ30 = 30'd652032874;
  localparam logic [21:0] SpeedMax = 22'd262143;
  localparam int MagShift = 38;

  typedef enum logic [1:0] {
    REG_HALF_LENGTH = 2'd0,
    REG_HALF_WIDTH  = 2'd1,
    REG_STOP_THRESH = 2'd2
  } swm_reg_t;

  typedef struct packed {
    logic [ProdW-1:0] prod;
    logic [31:0]      z;
    logic [15:0]      cur;
  } swm_lane_res_t;

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    case (i)
      0: r = 32'd536870912;
      1: r = 32'd316933406;
      2: r = 32'd167458907;
      3: r = 32'd85004756;
      4: r = 32'd42667331;
      5: r = 32'd21354465;
      6: r = 32'd10679838;
      7: r = 32'd5340245;
      8: r = 32'd2670163;
      9: r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/swm_lane.sv]
module swm_lane import swm_pkg::*; #(
  parameter int Steps = 16
) (
  input  logic                clk,
  input  logic [Steps+2:0]    en,
  input  logic signed [15:0]  vel_x,
  input  logic signed [15:0]  vel_y,
  input  logic signed [15:0]  yaw_rate,
  input  logic [15:0]         current_angle,
  input  logic signed [12:0]  pos_x,
  input  logic signed [12:0]  pos_y,
  output swm_lane_res_t       res
);

  logic signed [28:0] prod_y;
  logic signed [28:0] prod_x;
  logic signed [15:0] vx;
  logic signed [15:0] vy;
  logic [15:0] cur_s [0:Steps+2];
  logic signed [CordicW-1:0] x_s [0:Steps];
  logic signed [CordicW-1:0] y_s [0:Steps];
  logic [31:0] z_s [0:Steps];
  logic signed [19:0] wx;
  logic signed [19:0] wy;
  logic signed [CordicW-1:0] x0;
  logic signed [CordicW-1:0] y0;
  logic [ProdW-1:0] prod_m;
  logic [31:0] z_m;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_y <= 29'(yaw_rate) * 29'(pos_y);
      prod_x <= 29'(yaw_rate) * 29'(pos_x);
      vx <= vel_x;
      vy <= vel_y;
      cur_s[0] <= current_angle;
    end
  end

  always_comb begin
    wx = 20'(vx) + 20'(prod_y >>> 10);
    wy = 20'(vy) - 20'(prod_x >>> 10);
    x0 = CordicW'(wx) <<< 8;
    y0 = CordicW'(wy) <<< 8;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      cur_s[1] <= cur_s[0];
      if (x0 < 0) begin
        x_s[0] <= -x0;
        y_s[0] <= -y0;
        z_s[0] <= 32'h8000_0000;
      end else begin
        x_s[0] <= x0;
        y_s[0] <= y0;
        z_s[0] <= 32'd0;
      end
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en[2+i]) begin
        cur_s[2+i] <= cur_s[1+i];
        if (y_s[i] > 0) begin
          x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
          y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
          z_s[i+1] <= z_s[i] + atan_turn(i);
        end else begin
          x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
          y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
          z_s[i+1] <= z_s[i] - atan_turn(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[Steps+2]) begin
      prod_m <= ProdW'(x_s[Steps][CordicW-2:0]) * ProdW'(GainQ30);
      z_m <= z_s[Steps];
      cur_s[Steps+2] <= cur_s[Steps+1];
    end
  end

  assign res = '{prod: prod_m, z: z_m, cur: cur_s[Steps+2]};

endmodule

[hw/rtl/swm_merge.sv]
module swm_merge import swm_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [7:0]          stop_threshold,
  input  swm_lane_res_t       res [0:3],
  output logic [15:0]         steer_angle [0:3],
  output logic signed [18:0]  wheel_speed [0:3]
);

  logic [21:0] mag [0:3];
  logic [15:0] tgt [0:3];
  logic [15:0] err [0:3];
  logic [31:0] zr [0:3];
  logic flip [0:3];
  logic [15:0] ang_next [0:3];
  logic signed [18:0] spd_next [0:3];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mag[k] = 22'((res[k].prod + (ProdW'(1) << (MagShift - 1))) >> MagShift);
      if (mag[k] > SpeedMax) mag[k] = SpeedMax;
      zr[k] = res[k].z + 32'h0000_8000;
      tgt[k] = zr[k][31:16];
      err[k] = tgt[k] - res[k].cur;
      flip[k] = ($signed(err[k]) > 16'sd16384) || ($signed(err[k]) < -16'sd16384);
      if (mag[k] <= 22'(stop_threshold)) begin
        ang_next[k] = res[k].cur;
        spd_next[k] = '0;
      end else if (flip[k]) begin
        ang_next[k] = tgt[k] + 16'h8000;
        spd_next[k] = -$signed(mag[k][18:0]);
      end else begin
        ang_next[k] = tgt[k];
        spd_next[k] = $signed(mag[k][18:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      steer_angle <= ang_next;
      wheel_speed <= spd_next;
    end
  end

endmodule

[hw/rtl/swerve_module_solver_core.sv]
// Swerve drive inverse kinematics, four modules.
// Input channel: in_valid / in_stall with the chassis command and the four
// current steering angles. Output channel: out_valid / out_stall with the four
// target angles and signed wheel speeds. A transfer happens when valid is high
// and stall is low.
// Each module has its own lane: position products, CORDIC vectoring with one
// pipeline stage per iteration, gain multiply. A merge stage applies the
// stop threshold, the half-turn flip and saturation and holds the result.
// Throughput: one command per cycle while the output is not stalled.
// Each pipeline stage with a bubble keeps filling while the output is stalled;
// in_stall rises only when every stage holds a command and out_stall is high.
// Configuration: cfg_write with cfg_index 0 (half length), 1 (half width),
// 2 (stop threshold). Write only while the pipeline is empty.
// Reset: empties the pipeline, sets half length and width to 200 and the stop
// threshold to 0.
module swerve_module_solver_core import swm_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic signed [15:0] yaw_rate,
  input  logic [15:0]        current_angle_0,
  input  logic [15:0]        current_angle_1,
  input  logic [15:0]        current_angle_2,
  input  logic [15:0]        current_angle_3,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        target_angle_0,
  output logic [15:0]        target_angle_1,
  output logic [15:0]        target_angle_2,
  output logic [15:0]        target_angle_3,
  output logic signed [18:0] wheel_speed_0,
  output logic signed [18:0] wheel_speed_1,
  output logic signed [18:0] wheel_speed_2,
  output logic signed [18:0] wheel_speed_3
);

  localparam int Steps = (CORDIC_STEPS > MaxSteps) ? MaxSteps : CORDIC_STEPS;
  localparam int NumStages = Steps + 4;

  logic [11:0] base_half;
  logic [11:0] track_half;
  logic [7:0]  stop_threshold;
  logic [NumStages-1:0] stage_valid;
  logic [NumStages-1:0] en;
  logic [15:0] cur [0:3];
  logic signed [12:0] lx;
  logic signed [12:0] ly;
  logic signed [12:0] px [0:3];
  logic signed [12:0] py [0:3];
  swm_lane_res_t res [0:3];
  logic [15:0] tgt [0:3];
  logic signed [18:0] spd [0:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      base_half <= 12'd200;
      track_half <= 12'd200;
      stop_threshold <= 8'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HALF_LENGTH: base_half <= cfg_data;
        REG_HALF_WIDTH:  track_half <= cfg_data;
        REG_STOP_THRESH: stop_threshold <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    en[NumStages-1] = !stage_valid[NumStages-1] || !out_stall;
    for (int j = NumStages - 2; j >= 0; j--) begin
      en[j] = !stage_valid[j] || en[j+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (en[0]) stage_valid[0] <= in_valid;
      for (int j = 1; j < NumStages; j++) begin
        if (en[j]) stage_valid[j] <= stage_valid[j-1];
      end
    end
  end

  assign in_stall = !en[0];
  assign out_valid = stage_valid[NumStages-1];

  assign lx = 13'(base_half);
  assign ly = 13'(track_half);
  assign px = '{-lx, -lx, lx, lx};
  assign py = '{ly, -ly, ly, -ly};
  assign cur = '{current_angle_0, current_angle_1, current_angle_2, current_angle_3};

  for (genvar k = 0; k < 4; k++) begin : g_lane
    swm_lane #(.Steps(Steps)) u_lane (
      .clk          (clk),
      .en           (en[NumStages-2:0]),
      .vel_x        (vel_x),
      .vel_y        (vel_y),
      .yaw_rate     (yaw_rate),
      .current_angle(cur[k]),
      .pos_x        (px[k]),
      .pos_y        (py[k]),
      .res          (res[k])
    );
  end

  swm_merge u_merge (
    .clk           (clk),
    .en            (en[NumStages-1]),
    .stop_threshold(stop_threshold),
    .res           (res),
    .steer_angle   (tgt),
    .wheel_speed   (spd)
  );

  assign target_angle_0 = tgt[0];
  assign target_angle_1 = tgt[1];
  assign target_angle_2 = tgt[2];
  assign target_angle_3 = tgt[3];
  assign wheel_speed_0 = spd[0];
  assign wheel_speed_1 = spd[1];
  assign wheel_speed_2 = spd[2];
  assign wheel_speed_3 = spd[3];

  a_stall_needs_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

  a_empty_output_accepts: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output empty");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(wheel_speed_0)
      && $stable(target_angle_0)))
    else $error("stalled result lost or changed");

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb import swm_pkg::*; ();

  localparam int STEPS = 16;
  localparam int LATENCY = STEPS + 4;
  localparam int IDLE_LIMIT = 2000;
  localparam longint GAIN = 64'sd652032874;
  localparam longint SPEED_CAP = 64'sd262143;

  typedef struct {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] wz;
    logic [15:0]        cur[4];
  } chassis_cmd_t;

  typedef struct {
    logic [15:0] ang[4];
    logic [18:0] spd[4];
  } module_targets_t;

  logic clk, rst, cfg_write, in_valid, in_stall, out_valid, out_stall;
  logic [1:0] cfg_index;
  logic [11:0] cfg_data;
  logic signed [15:0] vel_x, vel_y, yaw_rate;
  logic [15:0] current_angle_0, current_angle_1, current_angle_2, current_angle_3;
  logic [15:0] target_angle_0, target_angle_1, target_angle_2, target_angle_3;
  logic signed [18:0] wheel_speed_0, wheel_speed_1, wheel_speed_2, wheel_speed_3;

  swerve_module_solver_core #(.CORDIC_STEPS(STEPS)) dut (.*);

  logic [31:0] arctan_lut [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  longint half_len, half_wid, stop_lvl;
  chassis_cmd_t cmd_queue[$];
  module_targets_t pending_targets[$];
  int sent, received, mismatches, idle_cycles, in_gap, out_hold;
  bit calm;

  function automatic void solve_lane(input longint px, input longint py, input chassis_cmd_t c,
                                     input logic [15:0] cur, output logic [15:0] ang,
                                     output logic [18:0] spd);
    longint x, y, xs, ys, mag;
    logic [31:0] z;
    logic [32:0] zr;
    logic [15:0] tgt;
    logic signed [15:0] err;
    x = (longint'(c.vx) + ((longint'(c.wz) * py) >>> 10)) * 256;
    y = (longint'(c.vy) - ((longint'(c.wz) * px) >>> 10)) * 256;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys;
        y -= xs;
        z += arctan_lut[i];
      end else begin
        x -= ys;
        y += xs;
        z -= arctan_lut[i];
      end
    end
    mag = (x * GAIN + (64'sd1 <<< 37)) >>> 38;
    if (mag > SPEED_CAP) mag = SPEED_CAP;
    if (mag <= stop_lvl) begin
      ang = cur;
      spd = '0;
    end else begin
      zr = {1'b0, z} + 33'h8000;
      tgt = zr[31:16];
      err = tgt - cur;
      if (err > 16384 || err < -16384) begin
        tgt = tgt + 16'h8000;
        mag = -mag;
      end
      ang = tgt;
      spd = mag[18:0];
    end
  endfunction

  function automatic module_targets_t solve_chassis(input chassis_cmd_t c);
    module_targets_t r;
    longint sx[4] = '{-1, -1, 1, 1};
    longint sy[4] = '{1, -1, 1, -1};
    for (int k = 0; k < 4; k++)
      solve_lane(sx[k] * half_len, sy[k] * half_wid, c, c.cur[k], r.ang[k], r.spd[k]);
    return r;
  endfunction

  function automatic chassis_cmd_t mk(input int vx, input int vy, input int wz,
                                      input int a);
    chassis_cmd_t c;
    c.vx = 16'(vx);
    c.vy = 16'(vy);
    c.wz = 16'(wz);
    for (int k = 0; k < 4; k++) c.cur[k] = 16'(a);
    return c;
  endfunction

  function automatic logic [15:0] rand_vel();
    int m;
    m = $urandom_range(0, 3);
    case (m)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 800) - 400);
      2: return 16'd0;
      default: return 16'($urandom_range(0, 8000) - 4000);
    endcase
  endfunction

  function automatic chassis_cmd_t rand_cmd();
    chassis_cmd_t c;
    c.vx = rand_vel();
    c.vy = rand_vel();
    c.wz = rand_vel();
    for (int k = 0; k < 4; k++) c.cur[k] = 16'($urandom);
    return c;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_targets.push_back(solve_chassis(cmd_queue[0]));
        void'(cmd_queue.pop_front());
        sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(0, 14);
          in_valid <= 0;
        end else if (cmd_queue.size() > 0) begin
          vel_x <= cmd_queue[0].vx;
          vel_y <= cmd_queue[0].vy;
          yaw_rate <= cmd_queue[0].wz;
          current_angle_0 <= cmd_queue[0].cur[0];
          current_angle_1 <= cmd_queue[0].cur[1];
          current_angle_2 <= cmd_queue[0].cur[2];
          current_angle_3 <= cmd_queue[0].cur[3];
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    module_targets_t got, want;
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.ang = '{target_angle_0, target_angle_1, target_angle_2, target_angle_3};
        got.spd = '{wheel_speed_0, wheel_speed_1, wheel_speed_2, wheel_speed_3};
        received++;
        if (pending_targets.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transfer at %0t", $realtime);
        end else begin
          want = pending_targets.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (got.ang[k] !== want.ang[k] || got.spd[k] !== want.spd[k]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("module %0d result %0d: angle exp %0d got %0d, speed exp %0d got %0d",
                         k, received, want.ang[k], got.ang[k],
                         $signed(want.spd[k]), $signed(got.spd[k]));
            end
          end
        end
      end
      if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_hold = $urandom_range(0, 14);
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic drain();
    while (cmd_queue.size() > 0 || pending_targets.size() > 0 || in_valid) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_geometry(input int l, input int w, input int thr);
    @(posedge clk);
    cfg_write <= 1;
    cfg_index <= REG_HALF_LENGTH;
    cfg_data <= 12'(l);
    @(posedge clk);
    cfg_index <= REG_HALF_WIDTH;
    cfg_data <= 12'(w);
    @(posedge clk);
    cfg_index <= REG_STOP_THRESH;
    cfg_data <= 12'(thr);
    @(posedge clk);
    cfg_write <= 0;
    half_len = l;
    half_wid = w;
    stop_lvl = thr;
  endtask

  task automatic add_random(input int n);
    repeat (n) cmd_queue.push_back(rand_cmd());
  endtask

  initial begin
    rst = 1;
    cfg_write = 0;
    cfg_index = REG_HALF_LENGTH;
    cfg_data = 0;
    in_valid = 0;
    out_stall = 0;
    vel_x = 0;
    vel_y = 0;
    yaw_rate = 0;
    current_angle_0 = 0;
    current_angle_1 = 0;
    current_angle_2 = 0;
    current_angle_3 = 0;
    half_len = 200;
    half_wid = 200;
    stop_lvl = 0;
    calm = 0;
    repeat (2) @(posedge clk);
    rst <= 0;

    cmd_queue.push_back(mk(0, 0, 0, 12345));
    cmd_queue.push_back(mk(1000, 0, 0, 0));
    cmd_queue.push_back(mk(1000, 0, 0, 32768));
    cmd_queue.push_back(mk(1000, 0, 0, 16384));
    cmd_queue.push_back(mk(1000, 0, 0, 16385));
    cmd_queue.push_back(mk(1000, 0, 0, 49152));
    cmd_queue.push_back(mk(1000, 0, 0, 49151));
    cmd_queue.push_back(mk(-1000, 0, 0, 0));
    cmd_queue.push_back(mk(-1000, 300, 0, 32768));
    cmd_queue.push_back(mk(0, 1000, 0, 65535));
    cmd_queue.push_back(mk(0, -1000, 0, 0));
    cmd_queue.push_back(mk(32767, 32767, 32767, 0));
    cmd_queue.push_back(mk(-32768, -32768, -32768, 65535));
    cmd_queue.push_back(mk(0, 0, 1024, 0));
    cmd_queue.push_back(mk(0, 0, -32768, 40000));
    cmd_queue.push_back(mk(1, 0, 0, 0));
    cmd_queue.push_back(mk(-1, -1, 0, 30000));
    add_random(220);
    drain();

    set_geometry(4095, 4095, 255);
    cmd_queue.push_back(mk(32767, 32767, 32767, 0));
    cmd_queue.push_back(mk(-32768, 32767, -32768, 0));
    cmd_queue.push_back(mk(255, 0, 0, 777));
    cmd_queue.push_back(mk(256, 0, 0, 777));
    add_random(220);
    drain();

    set_geometry(0, 0, 0);
    add_random(220);
    drain();

    set_geometry($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 255));
    add_random(220);
    drain();

    set_geometry(4095, 1, 12);
    add_random(150);
    drain();

    calm = 1;
    set_geometry(200, 200, 0);
    add_random(150);
    drain();

    $display("%0d commands sent, %0d results checked over six geometry/threshold settings",
             sent, received);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0 && pending_targets.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[swerve_module_solver_core.f]
hw/rtl/swm_pkg.sv
hw/rtl/swm_lane.sv
hw/rtl/swm_merge.sv
hw/rtl/swerve_module_solver_core.sv
test/tb.sv
